// ----- hw/rtl/spcm_pkg.sv -----
// Shared constants and types for the sprite priority and collision mixer.
package spcm_pkg;

    localparam int NUM_SPRITES = 8;
    localparam int PIX_W       = 5;
    localparam int MASK_W      = NUM_SPRITES;
    localparam int MODE_W      = 2;
    localparam int CFG_IDX_W   = 1;
    localparam int CFG_DATA_W  = 8;

    typedef logic [PIX_W-1:0]  pixel_t;
    typedef logic [MASK_W-1:0] mask_t;

    typedef enum logic [MODE_W-1:0] {
        MODE_PIXEL       = 2'd0,
        MODE_READ_SPRITE = 2'd1,
        MODE_READ_BG     = 2'd2
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_PRIORITY = 1'd0,
        CFG_DISPLAY  = 1'd1
    } cfg_index_t;

    typedef struct packed {
        logic   opaque;
        pixel_t color;
    } lane_t;

    typedef struct packed {
        pixel_t color;
        logic   written;
        mask_t  opaque;
        logic   sprite_hit;
        logic   bg_hit;
    } merge_t;

endpackage

// ----- hw/rtl/spcm_if.sv -----
// Valid/ready channel interfaces for pixel columns and mixer results.
interface spcm_in_if;
    logic                 valid;
    logic                 ready;
    logic [1:0]           mode;
    spcm_pkg::pixel_t     sprite_pixel_0;
    spcm_pkg::pixel_t     sprite_pixel_1;
    spcm_pkg::pixel_t     sprite_pixel_2;
    spcm_pkg::pixel_t     sprite_pixel_3;
    spcm_pkg::pixel_t     sprite_pixel_4;
    spcm_pkg::pixel_t     sprite_pixel_5;
    spcm_pkg::pixel_t     sprite_pixel_6;
    spcm_pkg::pixel_t     sprite_pixel_7;
    spcm_pkg::pixel_t     bg_collision_pixel;
    spcm_pkg::pixel_t     bg_render_pixel;

    modport source (
        output valid, mode, sprite_pixel_0, sprite_pixel_1, sprite_pixel_2, sprite_pixel_3,
               sprite_pixel_4, sprite_pixel_5, sprite_pixel_6, sprite_pixel_7,
               bg_collision_pixel, bg_render_pixel,
        input  ready
    );

    modport sink (
        input  valid, mode, sprite_pixel_0, sprite_pixel_1, sprite_pixel_2, sprite_pixel_3,
               sprite_pixel_4, sprite_pixel_5, sprite_pixel_6, sprite_pixel_7,
               bg_collision_pixel, bg_render_pixel,
        output ready
    );
endinterface

interface spcm_out_if;
    logic              valid;
    logic              ready;
    spcm_pkg::pixel_t  pixel_color;
    logic              pixel_written;
    spcm_pkg::mask_t   collision_mask;

    modport source (
        output valid, pixel_color, pixel_written, collision_mask,
        input  ready
    );

    modport sink (
        input  valid, pixel_color, pixel_written, collision_mask,
        output ready
    );
endinterface

// ----- hw/rtl/spcm_lane.sv -----
// One sprite lane: opacity test and the color this sprite shows if it wins.
module spcm_lane (
    input  spcm_pkg::pixel_t sprite_pixel,
    input  logic             bg_priority,
    input  spcm_pkg::pixel_t bg_collision_pixel,
    output spcm_pkg::lane_t  lane
);

    logic bg_opaque;

    assign bg_opaque = (bg_collision_pixel != '0);

    always_comb
    begin
        lane.opaque = (sprite_pixel != '0);
        if (bg_priority && bg_opaque)
        begin
            lane.color = bg_collision_pixel;
        end
        else
        begin
            lane.color = sprite_pixel;
        end
    end

endmodule

// ----- hw/rtl/spcm_merge.sv -----
// Merging stage: picks the lowest opaque lane, else the background render pixel, and flags collisions.
module spcm_merge (
    input  spcm_pkg::lane_t [spcm_pkg::NUM_SPRITES-1:0] lanes,
    input  spcm_pkg::pixel_t                            bg_collision_pixel,
    input  spcm_pkg::pixel_t                            bg_render_pixel,
    input  logic                                        display_enable,
    output spcm_pkg::merge_t                            result
);

    spcm_pkg::mask_t  opaque;
    spcm_pkg::pixel_t win_color;

    always_comb
    begin
        for (int i = 0; i < spcm_pkg::NUM_SPRITES; i++)
        begin
            opaque[i] = lanes[i].opaque;
        end
    end

    always_comb
    begin
        win_color = '0;
        for (int i = spcm_pkg::NUM_SPRITES - 1; i >= 0; i--)
        begin
            if (lanes[i].opaque)
            begin
                win_color = lanes[i].color;
            end
        end
    end

    always_comb
    begin
        result.opaque     = opaque;
        result.sprite_hit = ((opaque & (opaque - spcm_pkg::mask_t'(1))) != '0);
        result.bg_hit     = (opaque != '0) && (bg_collision_pixel != '0);
        result.color      = '0;
        result.written    = 1'b0;
        if (display_enable)
        begin
            if (opaque != '0)
            begin
                result.color   = win_color;
                result.written = 1'b1;
            end
            else if (bg_render_pixel != '0)
            begin
                result.color   = bg_render_pixel;
                result.written = 1'b1;
            end
        end
    end

endmodule

// ----- hw/rtl/sprite_priority_collision_mixer_core.sv -----
// Top level of the sprite priority and collision mixer.
// All lanes and the merge sit before one register; it holds a transfer's result from the cycle
// after the transfer. Throughput: one pixel column per cycle unless the output stalls.
// A new column is taken whenever the output register is empty or is being emptied.
// Reset clears the configuration registers, both collision masks and the output valid.
module sprite_priority_collision_mixer_core (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_write_en,
    input  logic [spcm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [spcm_pkg::CFG_DATA_W-1:0]      cfg_data,
    spcm_in_if.sink                              pix_in,
    spcm_out_if.source                           pix_out
);

    spcm_pkg::mask_t  priority_mask_reg;
    logic             display_enable_reg;
    spcm_pkg::mask_t  sprite_hit_reg;
    spcm_pkg::mask_t  sprite_hit_next;
    spcm_pkg::mask_t  bg_hit_reg;
    spcm_pkg::mask_t  bg_hit_next;
    logic             out_valid_reg;
    spcm_pkg::pixel_t color_reg;
    spcm_pkg::pixel_t color_next;
    logic             written_reg;
    logic             written_next;
    spcm_pkg::mask_t  mask_reg;
    spcm_pkg::mask_t  mask_next;

    logic             accept;
    spcm_pkg::pixel_t sprite_pixels [spcm_pkg::NUM_SPRITES];
    spcm_pkg::lane_t  [spcm_pkg::NUM_SPRITES-1:0] lanes;
    spcm_pkg::merge_t merged;

    assign pix_in.ready = !out_valid_reg || pix_out.ready;
    assign accept       = pix_in.valid && pix_in.ready;

    assign sprite_pixels[0] = pix_in.sprite_pixel_0;
    assign sprite_pixels[1] = pix_in.sprite_pixel_1;
    assign sprite_pixels[2] = pix_in.sprite_pixel_2;
    assign sprite_pixels[3] = pix_in.sprite_pixel_3;
    assign sprite_pixels[4] = pix_in.sprite_pixel_4;
    assign sprite_pixels[5] = pix_in.sprite_pixel_5;
    assign sprite_pixels[6] = pix_in.sprite_pixel_6;
    assign sprite_pixels[7] = pix_in.sprite_pixel_7;

    for (genvar g = 0; g < spcm_pkg::NUM_SPRITES; g++)
    begin : g_lane
        spcm_lane u_lane (
            .sprite_pixel       (sprite_pixels[g]),
            .bg_priority        (priority_mask_reg[g]),
            .bg_collision_pixel (pix_in.bg_collision_pixel),
            .lane               (lanes[g])
        );
    end

    spcm_merge u_merge (
        .lanes              (lanes),
        .bg_collision_pixel (pix_in.bg_collision_pixel),
        .bg_render_pixel    (pix_in.bg_render_pixel),
        .display_enable     (display_enable_reg),
        .result             (merged)
    );

    always_comb
    begin
        sprite_hit_next = sprite_hit_reg;
        bg_hit_next     = bg_hit_reg;
        color_next      = '0;
        written_next    = 1'b0;
        mask_next       = '0;
        case (spcm_pkg::mode_t'(pix_in.mode))
            spcm_pkg::MODE_PIXEL:
            begin
                color_next   = merged.color;
                written_next = merged.written;
                if (merged.sprite_hit)
                begin
                    sprite_hit_next = sprite_hit_reg | merged.opaque;
                end
                if (merged.bg_hit)
                begin
                    bg_hit_next = bg_hit_reg | merged.opaque;
                end
            end
            spcm_pkg::MODE_READ_SPRITE:
            begin
                mask_next       = sprite_hit_reg;
                sprite_hit_next = '0;
            end
            spcm_pkg::MODE_READ_BG:
            begin
                mask_next   = bg_hit_reg;
                bg_hit_next = '0;
            end
            default:
            begin
                mask_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            priority_mask_reg  <= '0;
            display_enable_reg <= 1'b0;
        end
        else if (cfg_write_en)
        begin
            case (spcm_pkg::cfg_index_t'(cfg_index))
                spcm_pkg::CFG_PRIORITY: priority_mask_reg  <= cfg_data[spcm_pkg::MASK_W-1:0];
                spcm_pkg::CFG_DISPLAY:  display_enable_reg <= cfg_data[0];
                default:                display_enable_reg <= display_enable_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sprite_hit_reg <= '0;
            bg_hit_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                sprite_hit_reg <= sprite_hit_next;
                bg_hit_reg     <= bg_hit_next;
                out_valid_reg  <= 1'b1;
            end
            else if (pix_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            color_reg   <= color_next;
            written_reg <= written_next;
            mask_reg    <= mask_next;
        end
    end

    assign pix_out.valid          = out_valid_reg;
    assign pix_out.pixel_color    = color_reg;
    assign pix_out.pixel_written  = written_reg;
    assign pix_out.collision_mask = mask_reg;

endmodule

// ----- hw/rtl/spcm_checker.sv -----
// Port-level assertions for the mixer top level and the bind that attaches them.
module spcm_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic [spcm_pkg::MODE_W-1:0] in_mode,
    input logic                        out_valid,
    input logic                        out_ready,
    input spcm_pkg::pixel_t            out_color,
    input logic                        out_written,
    input spcm_pkg::mask_t             out_mask
);

    logic in_xfer;
    logic out_stall;

    assign in_xfer   = in_valid && in_ready;
    assign out_stall = out_valid && !out_ready;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_stall |=> out_valid && $stable(out_color) && $stable(out_written)
            && $stable(out_mask))
        else $error("result changed while stalled");

    a_read_no_pixel: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_mode != spcm_pkg::MODE_PIXEL) |=>
            out_valid && !out_written && out_color == '0)
        else $error("read transfer produced a pixel");

    a_pixel_no_mask: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_mode == spcm_pkg::MODE_PIXEL) |=> out_valid && out_mask == '0)
        else $error("pixel transfer produced a collision mask");

    a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_written) |-> out_color == '0)
        else $error("unwritten pixel carries a color");

    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (in_xfer && in_mode == spcm_pkg::MODE_READ_SPRITE) ##1
        (in_xfer && in_mode == spcm_pkg::MODE_READ_SPRITE) |=> out_mask == '0)
        else $error("sprite collision mask not cleared by read");

endmodule

bind sprite_priority_collision_mixer_core spcm_checker u_spcm_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (pix_in.valid),
    .in_ready    (pix_in.ready),
    .in_mode     (pix_in.mode),
    .out_valid   (pix_out.valid),
    .out_ready   (pix_out.ready),
    .out_color   (pix_out.pixel_color),
    .out_written (pix_out.pixel_written),
    .out_mask    (pix_out.collision_mask)
);
